/* hw/rtl/number_text_formatter_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the number text formatter.
// Each macro expands to one labeled concurrent assertion, clocked on clk and
// held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef NUMBER_TEXT_FORMATTER_MACROS_SVH
`define NUMBER_TEXT_FORMATTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NTF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NTF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/ntf_pkg.sv */
// ----------------------------------------------------------------------------
// ntf_pkg: number text formatter package
// Sizes, codes, reciprocal constants and character helpers of the formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package ntf_pkg;

	localparam int MAX_PAD    = 16;
	localparam int RESULT_CAP = 20;
	// The sign plus the padded digits never exceed the result cap.
	localparam int PAD_CAP    = (MAX_PAD < RESULT_CAP - 1) ? MAX_PAD : RESULT_CAP - 1;
	localparam int DEC_DIGITS = 10;
	localparam int DIG_DEPTH  = (PAD_CAP > DEC_DIGITS) ? PAD_CAP : DEC_DIGITS;
	localparam int IDX_W      = $clog2(DIG_DEPTH);
	localparam int CNT_W      = $clog2(DIG_DEPTH + 1);

	localparam logic [31:0] ROMAN_LIMIT  = 32'd40000;
	localparam logic [4:0]  ROMAN_DIGITS = 5'd5;

	localparam logic [4:0] RADIX_DEC   = 5'd10;
	localparam logic [4:0] RADIX_HEX   = 5'd16;
	localparam logic [4:0] RADIX_ALPHA = 5'd26;

	// floor(2^32 / radix); the estimated quotient is low by at most one.
	localparam logic [31:0] RECIP_DEC   = 32'h1999_9999;
	localparam logic [31:0] RECIP_HEX   = 32'h1000_0000;
	localparam logic [31:0] RECIP_ALPHA = 32'h09D8_9D89;

	localparam logic [6:0] CHAR_MINUS = 7'h2d;
	localparam logic [6:0] CHAR_ZERO  = 7'h30;
	localparam logic [6:0] CHAR_UP_A  = 7'h41;
	localparam logic [6:0] CHAR_LO_A  = 7'h61;

	typedef enum logic [2:0] {
		REQ_DEC      = 3'd0,
		REQ_HEX_LO   = 3'd1,
		REQ_HEX_UP   = 3'd2,
		REQ_ROM_LO   = 3'd3,
		REQ_ROM_UP   = 3'd4,
		REQ_ALPHA_LO = 3'd5,
		REQ_ALPHA_UP = 3'd6
	} req_type_t;

	typedef enum logic [1:0] {
		MODE_DEC,
		MODE_HEX,
		MODE_ROMAN,
		MODE_ALPHA
	} fmt_mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_FIX,
		ST_SIGN,
		ST_EMIT,
		ST_FLUSH
	} ntf_state_t;

	// Lower-case Roman "one" letter of a decimal position.
	function automatic logic [6:0] roman_one(input logic [2:0] p);
		logic [6:0] c;
		unique case (p)
			3'd0:    c = 7'h69; // i
			3'd1:    c = 7'h78; // x
			3'd2:    c = 7'h63; // c
			3'd3:    c = 7'h6d; // m
			default: c = 7'h7a; // z
		endcase
		return c;
	endfunction

	// Lower-case Roman "five" letter of a decimal position.
	function automatic logic [6:0] roman_five(input logic [2:0] p);
		logic [6:0] c;
		unique case (p)
			3'd0:    c = 7'h76; // v
			3'd1:    c = 7'h6c; // l
			3'd2:    c = 7'h64; // d
			default: c = 7'h77; // w
		endcase
		return c;
	endfunction

	// Number of Roman letters that one decimal digit expands to.
	function automatic logic [2:0] roman_len(input logic [4:0] d);
		logic [2:0] n;
		unique case (d)
			5'd0:    n = 3'd0;
			5'd1:    n = 3'd1;
			5'd2:    n = 3'd2;
			5'd3:    n = 3'd3;
			5'd4:    n = 3'd2;
			5'd5:    n = 3'd1;
			5'd6:    n = 3'd2;
			5'd7:    n = 3'd3;
			5'd8:    n = 3'd4;
			5'd9:    n = 3'd2;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/ntf_if.sv */
// ----------------------------------------------------------------------------
// ntf_if: formatter stream interfaces
// Valid/ready channels for number requests and for text characters.
// ----------------------------------------------------------------------------
`default_nettype none

interface ntf_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic        [2:0]  req_type;
	logic        [4:0]  pad_width;

	modport source (output valid, output value, output req_type, output pad_width,
		input ready);
	modport sink (input valid, input value, input req_type, input pad_width,
		output ready);
endinterface

interface ntf_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] char_code;
	logic       last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

/* hw/rtl/number_text_formatter.sv */
// ----------------------------------------------------------------------------
// number_text_formatter: signed integer to ASCII text
// Formats one 32-bit number as decimal, hex, Roman or letters, one character
// per output request.
// ----------------------------------------------------------------------------
// Usage: a request on num carries value, req_type and pad_width. The text
// leaves on text most significant character first, one character per
// request, and the final character of the number has last_char set. Every
// number yields 1 to 20 characters.
// Timing: num.ready is high only while the block is idle. The digits are
// produced by one shared reciprocal-multiply divider, in a multiply state
// and a fix state per digit (5 digits for Roman, else the larger of the
// digit count and the pad width). A sign state then handles the minus, and
// the characters after it go out one per cycle while the receiver does not
// stall; each Roman position with digit zero takes a sequencer step too.
// Reset: arst_n clears the sequencer and the output register; no character
// is pending afterwards and the block is ready at once.
// Stalls: one character is held back so that the final one can be marked;
// a stalled receiver freezes character generation, and nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module number_text_formatter (
	input  logic      clk,
	input  logic      arst_n,
	ntf_in_if.sink    num,
	ntf_out_if.source text
);
	import ntf_pkg::*;

	`include "number_text_formatter_macros.svh"

	// Sequencer and per-item registers.
	ntf_state_t       state_q, state_d;
	fmt_mode_t        mode_q;
	logic             upper_q;
	logic             neg_q;
	logic [31:0]      mag_q;
	logic [31:0]      opnd_q;
	logic [63:0]      prod_q;
	logic [4:0]       pad_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] idx_q;
	logic [1:0]       sub_q;
	logic [4:0]       dig_q [DIG_DEPTH];

	// The held character, and the output register that faces the receiver.
	logic [6:0] hold_char_q;
	logic       hold_valid_q;
	logic [6:0] out_char_q;
	logic       out_last_q;
	logic       out_valid_q;

	// Request decode. The magnitude of the most negative value is taken as
	// the unsigned 2^31, which the 32-bit negation gives by itself.
	logic [31:0] raw_u;
	logic [31:0] in_mag;
	logic        in_rom;
	logic        in_alpha;
	logic        in_hex;
	logic [4:0]  pad_sat;
	fmt_mode_t   in_mode;
	logic [4:0]  in_pad;
	logic        in_upper;

	always_comb begin
		raw_u    = num.value;
		in_mag   = raw_u[31] ? (32'd0 - raw_u) : raw_u;
		in_rom   = (num.req_type == REQ_ROM_LO || num.req_type == REQ_ROM_UP) &&
			(in_mag != 32'd0) && (in_mag < ROMAN_LIMIT);
		in_alpha = (num.req_type == REQ_ALPHA_LO || num.req_type == REQ_ALPHA_UP) &&
			(in_mag != 32'd0);
		in_hex   = (num.req_type == REQ_HEX_LO || num.req_type == REQ_HEX_UP);
		in_upper = (num.req_type == REQ_HEX_UP || num.req_type == REQ_ROM_UP ||
			num.req_type == REQ_ALPHA_UP);
		pad_sat  = (num.pad_width > 5'(PAD_CAP)) ? 5'(PAD_CAP) : num.pad_width;
		// Roman extracts all five decimal positions; a fallback to decimal
		// from Roman, letters or the unused code is not padded.
		priority if (in_rom) begin
			in_mode = MODE_ROMAN;
			in_pad  = ROMAN_DIGITS;
		end else if (in_alpha) begin
			in_mode = MODE_ALPHA;
			in_pad  = 5'd0;
		end else if (in_hex) begin
			in_mode = MODE_HEX;
			in_pad  = pad_sat;
		end else if (num.req_type == REQ_DEC) begin
			in_mode = MODE_DEC;
			in_pad  = pad_sat;
		end else begin
			in_mode = MODE_DEC;
			in_pad  = 5'd0;
		end
	end

	// Shared divider: quotient estimate by reciprocal multiply, then one
	// compare and subtract. Letters are bijective, so they divide mag - 1.
	logic [4:0]  radix;
	logic [31:0] recip;
	logic [31:0] opnd;
	logic [31:0] q_est;
	logic [31:0] q_back;
	logic [31:0] rem_full;
	logic        rem_over;
	logic [4:0]  digit;
	logic [31:0] quot;
	logic [5:0]  cnt_next;
	logic        more_digits;

	always_comb begin
		unique case (mode_q)
			MODE_HEX: begin
				radix = RADIX_HEX;
				recip = RECIP_HEX;
			end
			MODE_ALPHA: begin
				radix = RADIX_ALPHA;
				recip = RECIP_ALPHA;
			end
			default: begin
				radix = RADIX_DEC;
				recip = RECIP_DEC;
			end
		endcase
		opnd        = (mode_q == MODE_ALPHA) ? (mag_q - 32'd1) : mag_q;
		q_est       = prod_q[63:32];
		q_back      = q_est * {27'd0, radix};
		rem_full    = opnd_q - q_back;
		// The remainder estimate stays below twice the radix.
		rem_over    = rem_full[5:0] >= {1'b0, radix};
		digit       = rem_over ? 5'(rem_full[5:0] - {1'b0, radix}) : rem_full[4:0];
		quot        = q_est + {31'd0, rem_over};
		cnt_next    = 6'(cnt_q) + 6'd1;
		more_digits = (quot != 32'd0) || (cnt_next < {1'b0, pad_q});
	end

	// Character of the digit at the read position.
	logic [CNT_W-1:0] rd_pos;
	logic [4:0]       rd_digit;
	logic [2:0]       rom_pos;
	logic [2:0]       rom_len;
	logic             rom_digit_end;
	logic [6:0]       rom_char_lo;
	logic [6:0]       rom_char;
	logic [6:0]       radix_char;
	logic [6:0]       emit_char;

	always_comb begin
		rd_pos        = idx_q - CNT_W'(1);
		rd_digit      = dig_q[rd_pos[IDX_W-1:0]];
		rom_pos       = rd_pos[2:0];
		rom_len       = roman_len(rd_digit);
		rom_digit_end = ({1'b0, sub_q} + 3'd1) == rom_len;
		// Nine is one-then-next-one, four is one-then-five, five and up lead
		// with five, and the rest are runs of ones.
		priority if (rd_digit == 5'd9) begin
			rom_char_lo = (sub_q == 2'd0) ? roman_one(rom_pos) : roman_one(rom_pos + 3'd1);
		end else if (rd_digit == 5'd4) begin
			rom_char_lo = (sub_q == 2'd0) ? roman_one(rom_pos) : roman_five(rom_pos);
		end else if (rd_digit >= 5'd5) begin
			rom_char_lo = (sub_q == 2'd0) ? roman_five(rom_pos) : roman_one(rom_pos);
		end else begin
			rom_char_lo = roman_one(rom_pos);
		end
		rom_char = upper_q ? {rom_char_lo[6], 1'b0, rom_char_lo[4:0]} : rom_char_lo;
		if (rd_digit < 5'd10) begin
			radix_char = CHAR_ZERO + {2'b00, rd_digit};
		end else begin
			radix_char = (upper_q ? CHAR_UP_A : CHAR_LO_A) + {2'b00, rd_digit - 5'd10};
		end
		unique case (mode_q)
			MODE_ROMAN: emit_char = rom_char;
			MODE_ALPHA: emit_char = (upper_q ? CHAR_UP_A : CHAR_LO_A) + {2'b00, rd_digit};
			default:    emit_char = radix_char;
		endcase
	end

	// Sequencer.
	logic       out_free;
	logic       go;
	logic       accept;
	logic       dig_wr;
	logic       gen;
	logic [6:0] gen_char;
	logic       idx_dec;
	logic       sub_inc;
	logic       flush_push;

	assign out_free = !out_valid_q || text.ready;
	assign go       = !hold_valid_q || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		accept     = 1'b0;
		dig_wr     = 1'b0;
		gen        = 1'b0;
		gen_char   = emit_char;
		idx_dec    = 1'b0;
		sub_inc    = 1'b0;
		flush_push = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (num.valid) begin
					accept  = 1'b1;
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_FIX;
			end
			ST_FIX: begin
				dig_wr  = 1'b1;
				state_d = more_digits ? ST_MUL : ST_SIGN;
			end
			ST_SIGN: begin
				gen_char = CHAR_MINUS;
				if (!neg_q) begin
					state_d = ST_EMIT;
				end else if (go) begin
					gen     = 1'b1;
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (mode_q == MODE_ROMAN && rom_len == 3'd0) begin
					// A zero position has no Roman letters.
					idx_dec = 1'b1;
				end else if (go) begin
					gen = 1'b1;
					if (mode_q != MODE_ROMAN || rom_digit_end) begin
						idx_dec = 1'b1;
					end else begin
						sub_inc = 1'b1;
					end
				end
				if (idx_dec && idx_q == CNT_W'(1)) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					flush_push = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			idx_q        <= '0;
			sub_q        <= '0;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q <= '0;
				sub_q <= '0;
			end else if (dig_wr) begin
				cnt_q <= cnt_q + CNT_W'(1);
				idx_q <= cnt_q + CNT_W'(1);
			end
			if (idx_dec) begin
				idx_q <= idx_q - CNT_W'(1);
				sub_q <= '0;
			end else if (sub_inc) begin
				sub_q <= sub_q + 2'd1;
			end
			if (gen) begin
				hold_valid_q <= 1'b1;
			end else if (flush_push) begin
				hold_valid_q <= 1'b0;
			end
			if ((gen && hold_valid_q) || flush_push) begin
				out_valid_q <= 1'b1;
			end else if (text.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q   <= raw_u[31];
			mag_q   <= in_mag;
			mode_q  <= in_mode;
			upper_q <= in_upper;
			pad_q   <= in_pad;
		end
		if (state_q == ST_MUL) begin
			opnd_q <= opnd;
			prod_q <= {32'd0, opnd} * {32'd0, recip};
		end
		if (dig_wr) begin
			dig_q[cnt_q[IDX_W-1:0]] <= digit;
			mag_q                   <= quot;
		end
		if (gen) begin
			hold_char_q <= gen_char;
			if (hold_valid_q) begin
				out_char_q <= hold_char_q;
				out_last_q <= 1'b0;
			end
		end else if (flush_push) begin
			out_char_q <= hold_char_q;
			out_last_q <= 1'b1;
		end
	end

	assign num.ready      = (state_q == ST_IDLE);
	assign text.valid     = out_valid_q;
	assign text.char_code = out_char_q;
	assign text.last_char = out_last_q;

	// Assertions.
	`NTF_ASSERT_NOW(a_idle_no_hold, state_q == ST_IDLE, !hold_valid_q,
		"character still held while idle")
	`NTF_ASSERT_NOW(a_flush_has_char, state_q == ST_FLUSH, hold_valid_q,
		"flush without a held character")
	`NTF_ASSERT_NOW(a_cnt_depth, 1'b1, cnt_q <= CNT_W'(DIG_DEPTH),
		"digit count beyond buffer depth")
	`NTF_ASSERT_NOW(a_dec_digit, (state_q == ST_EMIT) &&
		(mode_q == MODE_DEC || mode_q == MODE_ROMAN), rd_digit < 5'd10,
		"decimal digit out of range")
	`NTF_ASSERT_NEXT(a_gen_needs_room, gen && hold_valid_q, out_valid_q,
		"held character not moved to the output register")

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: number text formatter verification
// Sends signed numbers with every format kind and pad width, predicts the
// ASCII text of each one, and checks every character and its last flag as it
// leaves the formatter, under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module testbench;

	import ntf_pkg::*;

	// Type code 7 has no enum member; the formatter treats it as plain decimal.
	localparam logic [2:0] REQ_SPARE = 3'd7;

	// Bounds of the text formats.
	localparam int unsigned ROMAN_CEILING = 40000;
	localparam int unsigned LETTER_BASE   = 26;
	localparam int          TEXT_CAP      = 20;
	localparam int          PAD_LIMIT     = (MAX_PAD < TEXT_CAP - 1) ? MAX_PAD : TEXT_CAP - 1;

	// Run limits. The slowest correct run (every item at its longest text, the
	// receiver stalling most cycles) stays well under RUN_LIMIT.
	localparam int unsigned RUN_LIMIT = 1_000_000;
	localparam int          END_SLACK = 60;

	// One character of formatted text as the receiver sees it.
	typedef struct packed {
		logic [6:0] char_code;
		logic       last_char;
	} text_char_t;

	logic clk;
	logic arst_n;

	ntf_in_if  num_ch ();
	ntf_out_if text_ch ();

	number_text_formatter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.num    (num_ch),
		.text   (text_ch)
	);

	// Characters still owed by the formatter, oldest first.
	text_char_t pending_chars[$];

	int          fault_count = 0;
	int unsigned cycle_count = 0;

	// Chance, in percent per cycle, that the sender holds back a request or
	// that the receiver refuses a character.
	int send_idle_pct = 0;
	int stall_pct     = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Predicts the text of one number and appends its characters to the
	// queue of pending characters. Negative values get a leading minus and
	// the magnitude is formatted; the magnitude of the most negative value is
	// read as unsigned. Roman and letters fall back to plain decimal when
	// they cannot express the magnitude, and so does the spare type code.
	function automatic void predict_text(input logic [31:0] raw, input logic [2:0] kind,
			input logic [4:0] pad_in);
		byte         txt [0:47];
		byte         rev [0:TEXT_CAP-1];
		string       one;
		string       five;
		string       digits;
		byte         base;
		logic [31:0] mag;
		int unsigned scale;
		int unsigned d;
		int unsigned radix;
		int          n;
		int          r;
		int          p;
		int          k;
		int          pad;
		int          fill;
		bit          upper;

		mag = raw[31] ? (32'd0 - raw) : raw;
		pad = (pad_in > PAD_LIMIT) ? PAD_LIMIT : int'(pad_in);
		n = 0;
		if (raw[31]) begin
			txt[n] = "-";
			n++;
		end

		if ((kind == REQ_ROM_LO || kind == REQ_ROM_UP) && mag > 0 && mag < ROMAN_CEILING) begin
			upper = (kind == REQ_ROM_UP);
			if (upper) begin
				one  = "IXCMZ";
				five = "VLDW";
			end else begin
				one  = "ixcmz";
				five = "vldw";
			end
			// Position 4 is tens of thousands (z); below the ceiling its digit
			// is at most 3, so the nine and four forms never reach it.
			scale = 10000;
			for (p = 4; p >= 0; p--) begin
				d = (mag / scale) % 10;
				scale = scale / 10;
				if (d == 9) begin
					txt[n] = one[p];
					txt[n+1] = one[p+1];
					n += 2;
				end else if (d == 4) begin
					txt[n] = one[p];
					txt[n+1] = five[p];
					n += 2;
				end else begin
					if (d >= 5) begin
						txt[n] = five[p];
						n++;
						d -= 5;
					end
					for (k = 0; k < d; k++) begin
						txt[n] = one[p];
						n++;
					end
				end
			end
		end else if ((kind == REQ_ALPHA_LO || kind == REQ_ALPHA_UP) && mag > 0) begin
			// Bijective base 26: a..z, aa, ab, ...
			if (kind == REQ_ALPHA_UP)
				base = "A";
			else
				base = "a";
			r = 0;
			while (mag != 0) begin
				rev[r] = base + byte'((mag - 1) % LETTER_BASE);
				mag = (mag - 1) / LETTER_BASE;
				r++;
			end
			while (r > 0) begin
				r--;
				txt[n] = rev[r];
				n++;
			end
		end else begin
			if (kind == REQ_HEX_UP)
				digits = "0123456789ABCDEF";
			else
				digits = "0123456789abcdef";
			radix = (kind == REQ_HEX_LO || kind == REQ_HEX_UP) ? 16 : 10;
			// Padding applies to decimal and hex requests only, never to a
			// fallback from Roman or letters.
			fill = (kind == REQ_DEC || kind == REQ_HEX_LO || kind == REQ_HEX_UP) ? pad : 0;
			r = 0;
			do begin
				rev[r] = digits[int'(mag % radix)];
				mag = mag / radix;
				r++;
			end while (mag != 0 && r < TEXT_CAP);
			while (r < fill && r < TEXT_CAP) begin
				rev[r] = "0";
				r++;
			end
			while (r > 0) begin
				r--;
				txt[n] = rev[r];
				n++;
			end
		end

		if (n > TEXT_CAP)
			n = TEXT_CAP;
		for (k = 0; k < n; k++)
			pending_chars.push_back({txt[k][6:0], k == n - 1});
	endfunction

	// The receiver refuses characters at random, at the rate of the phase.
	always @(posedge clk)
		text_ch.ready <= ($urandom_range(99, 0) >= stall_pct);

	// Every accepted character is matched against the oldest prediction.
	// Sampling in the active region at the edge sees the values the formatter
	// saw, since all its state moves by nonblocking assignment.
	always @(posedge clk) begin
		text_char_t want;
		if (arst_n && text_ch.valid && text_ch.ready) begin
			if (pending_chars.size() == 0) begin
				$error("character %h with last_char %b arrived with nothing expected",
					text_ch.char_code, text_ch.last_char);
				fault_count++;
			end else begin
				want = pending_chars.pop_front();
				if (text_ch.char_code !== want.char_code) begin
					$error("char_code: expected %h, got %h", want.char_code,
						text_ch.char_code);
					fault_count++;
				end
				if (text_ch.last_char !== want.last_char) begin
					$error("last_char: expected %b, got %b", want.last_char,
						text_ch.last_char);
					fault_count++;
				end
			end
		end
	end

	// A hung formatter ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= RUN_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Offers one number and waits until the formatter takes it. The request
	// is held back at random first; valid is only lowered during that gap,
	// so back-to-back requests keep it high across the edge.
	task automatic send_number(input logic [31:0] v, input logic [2:0] kind,
			input logic [4:0] pad);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			num_ch.valid <= 1'b0;
			@(posedge clk);
		end
		num_ch.valid     <= 1'b1;
		num_ch.value     <= v;
		num_ch.req_type  <= kind;
		num_ch.pad_width <= pad;
		do
			@(posedge clk);
		while (!num_ch.ready);
		predict_text(v, kind, pad);
	endtask

	// Stops requesting and waits until every predicted character has left.
	// At least one edge passes, so valid is never driven twice in one step.
	task automatic wait_text_drained();
		num_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_chars.size() != 0);
	endtask

	// Extremes of every field, each format and each fallback.
	task automatic test_corner_cases();
		send_number(32'd0,            REQ_DEC,      5'd0);
		send_number(32'h8000_0000,    REQ_DEC,      5'd0);
		send_number(32'h7fff_ffff,    REQ_DEC,      5'd16);
		send_number(-32'sd5,          REQ_DEC,      5'd31);
		send_number(32'd7,            REQ_DEC,      5'd1);
		send_number(32'h7fff_ffff,    REQ_HEX_LO,   5'd16);
		send_number(32'h8000_0000,    REQ_HEX_LO,   5'd0);
		send_number(32'hffff_ffff,    REQ_HEX_UP,   5'd0);
		send_number(32'd0,            REQ_HEX_UP,   5'd17);
		send_number(32'h00ab_cdef,    REQ_HEX_UP,   5'd8);
		send_number(32'd39999,        REQ_ROM_LO,   5'd0);
		send_number(32'd38888,        REQ_ROM_UP,   5'd0);
		send_number(32'd40000,        REQ_ROM_LO,   5'd9);
		send_number(32'd0,            REQ_ROM_UP,   5'd4);
		send_number(-32'sd1994,       REQ_ROM_LO,   5'd0);
		send_number(32'd1,            REQ_ROM_UP,   5'd0);
		send_number(32'd1,            REQ_ALPHA_LO, 5'd0);
		send_number(32'd26,           REQ_ALPHA_UP, 5'd0);
		send_number(32'd27,           REQ_ALPHA_LO, 5'd0);
		send_number(32'h8000_0000,    REQ_ALPHA_UP, 5'd0);
		send_number(32'd0,            REQ_ALPHA_LO, 5'd12);
		send_number(32'h7fff_ffff,    REQ_ALPHA_LO, 5'd0);
		send_number(-32'sd123,        REQ_SPARE,    5'd16);
		send_number(32'h8000_0000,    REQ_ROM_UP,   5'd31);
		wait_text_drained();
	endtask

	// A stream of random numbers. Values are drawn from several pools so that
	// Roman, letters, padding and the sign all see plenty of traffic, and
	// every bit of every field toggles.
	task automatic test_random_format(input int count);
		logic [31:0] v;
		logic [4:0]  pad;
		int          i;
		for (i = 0; i < count; i++) begin
			case ($urandom_range(5, 0))
				0: v = $urandom;
				1: v = $urandom_range(ROMAN_CEILING - 1, 0);
				2: v = 32'd0 - $urandom_range(ROMAN_CEILING - 1, 1);
				3: v = $urandom_range(1000, 0);
				4: begin
					case ($urandom_range(5, 0))
						0: v = 32'h8000_0000;
						1: v = 32'h7fff_ffff;
						2: v = 32'd0;
						3: v = 32'hffff_ffff;
						4: v = ROMAN_CEILING;
						default: v = ROMAN_CEILING - 1;
					endcase
				end
				default: begin
					v = $urandom >> $urandom_range(31, 0);
					if ($urandom_range(1, 0) == 1)
						v = 32'd0 - v;
				end
			endcase
			if ($urandom_range(3, 0) == 0)
				pad = 5'($urandom_range(31, 0));
			else
				pad = 5'($urandom_range(MAX_PAD, 0));
			send_number(v, 3'($urandom_range(7, 0)), pad);
		end
		wait_text_drained();
	endtask

	// Each request waits until the text of the one before has fully left.
	task automatic test_paced_requests(input int count);
		int i;
		for (i = 0; i < count; i++) begin
			send_number($urandom, 3'($urandom_range(7, 0)), 5'($urandom_range(31, 0)));
			wait_text_drained();
		end
	endtask

	initial begin
		arst_n            = 1'b0;
		num_ch.valid      = 1'b0;
		num_ch.value      = '0;
		num_ch.req_type   = '0;
		num_ch.pad_width  = '0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// No idling on either side.
		send_idle_pct = 0;
		stall_pct     = 0;
		test_corner_cases();
		test_random_format(85);

		// Sender mostly idle.
		send_idle_pct = 84;
		stall_pct     = 0;
		test_random_format(85);

		// Receiver mostly stalling.
		send_idle_pct = 0;
		stall_pct     = 84;
		test_random_format(85);

		// Both sides idle now and then.
		send_idle_pct = 28;
		stall_pct     = 28;
		test_random_format(85);
		test_paced_requests(12);

		// Give any straggling character time to show up as unexpected.
		repeat (END_SLACK) @(posedge clk);
		if (fault_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
